[design/pem_pkg.sv]
// ---------------------------------------------------------------------------
// pem_pkg
// Types and constants shared by the pulse energy meter modules.
// ---------------------------------------------------------------------------
package pem_pkg;

  localparam int CNT_W    = 32;
  localparam int PWR_W    = 14;
  localparam int AVG_W    = 32;
  localparam int EN_W     = 42;
  localparam int PPU_W    = 16;
  localparam int DVD_W    = 54;
  localparam int DVS_W    = 32;
  localparam int NUM_CNT  = 5;
  localparam int IDX_W    = 3;
  localparam int DCNT_W   = 6;
  localparam int PADDR_W  = 3;

  localparam logic [31:0]      TIMEOUT_MS = 32'd3000000;
  localparam logic [DVD_W-1:0] POWER_NUM  = 54'd3600000000;
  localparam logic [PWR_W-1:0] POWER_CLIP = 14'd9999;
  localparam logic [PPU_W-1:0] PPU_RESET  = 16'd1000;

  typedef enum logic [2:0] {
    OP_PULSE     = 3'd0,
    OP_EVAL      = 3'd1,
    OP_CNT_RESET = 3'd2,
    OP_CNT_LOAD  = 3'd3,
    OP_PEAK_RST  = 3'd4,
    OP_AVG_RST   = 3'd5
  } pem_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PWR_A_GO,
    ST_PWR_A_WAIT,
    ST_PWR_B_GO,
    ST_PWR_B_WAIT,
    ST_EN_GO,
    ST_EN_WAIT,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_DONE
  } pem_state_t;

endpackage

[design/pem_intf.sv]
// ---------------------------------------------------------------------------
// pem_in_if / pem_out_if
// Valid/ready channels carrying meter items and results.
// ---------------------------------------------------------------------------
interface pem_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] time_ms;
  logic [31:0] time_s;
  logic [4:0]  counter_mask;
  logic [31:0] load_value;

  modport source(output valid, opcode, time_ms, time_s, counter_mask, load_value,
                 input ready);
  modport sink(input valid, opcode, time_ms, time_s, counter_mask, load_value,
               output ready);
endinterface

interface pem_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] power_now;
  logic [13:0] power_max;
  logic [31:0] power_avg;
  logic [41:0] energy_today;
  logic [41:0] energy_week;
  logic [41:0] energy_month;
  logic [41:0] energy_year;
  logic [41:0] energy_all;
  logic        idle_timeout;

  modport source(output valid, power_now, power_max, power_avg, energy_today,
                 energy_week, energy_month, energy_year, energy_all, idle_timeout,
                 input ready);
  modport sink(input valid, power_now, power_max, power_avg, energy_today,
               energy_week, energy_month, energy_year, energy_all, idle_timeout,
               output ready);
endinterface

[design/pem_cfg.sv]
// ---------------------------------------------------------------------------
// pem_cfg
// APB register file holding pulses_per_unit.
// ---------------------------------------------------------------------------
module pem_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pem_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [pem_pkg::PPU_W-1:0]   ppu
);

  logic [pem_pkg::PPU_W-1:0] ppu_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign ppu    = ppu_r;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, ppu_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppu_r <= pem_pkg::PPU_RESET;
    end else if (wr_en) begin
      ppu_r <= pwdata[pem_pkg::PPU_W-1:0];
    end
  end

endmodule

[design/pem_div.sv]
// ---------------------------------------------------------------------------
// pem_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pem_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pem_pkg::DVD_W-1:0] dividend,
  input  logic [pem_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [pem_pkg::DVD_W-1:0] quotient
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [pem_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [pem_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [pem_pkg::DVS_W-1:0]  div_r, div_nxt;
  logic [pem_pkg::DVD_W-1:0]  quo_r, quo_nxt;
  logic [pem_pkg::DVS_W:0]    trial;
  logic [pem_pkg::DVS_W:0]    diffv;
  logic                       ge;

  assign trial = {rem_r, quo_r[pem_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diffv = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diffv[pem_pkg::DVS_W-1:0] : trial[pem_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[pem_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pem_pkg::DCNT_W'(pem_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[design/pulse_energy_meter.sv]
// ---------------------------------------------------------------------------
// pulse_energy_meter
// Meter-pulse energy block: interval power, peak, period energies, average.
//
//   channel  | dir | handshake          | content
//   in_ch    | in  | valid/ready        | opcode, time_ms, time_s, mask, load
//   out_ch   | out | valid/ready        | power, peak, average, 5 energies, idle
//   cfg_*    | in  | APB, pready high   | pulses_per_unit at 0x0
//
// Non-evaluate items make no divider pass; evaluate makes up to eight
// passes (start, 54 quotient bits, done) through the one bit-serial
// divider: two for power, five for energies and one for the average.
// One item at a time; a result waits in the output register while the
// next item is taken. Synchronous active-low reset, no clearing pass.
// ---------------------------------------------------------------------------
module pulse_energy_meter (
  input  logic                        clk,
  input  logic                        rst_n,
  pem_in_if.sink                      in_ch,
  pem_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pem_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  pem_pkg::pem_state_t state_r, state_nxt;

  logic [pem_pkg::PPU_W-1:0] ppu, ppu_eff;
  logic                      div_start, div_done;
  logic [pem_pkg::DVD_W-1:0] div_dvd, div_quo;
  logic [pem_pkg::DVS_W-1:0] div_dvs;

  logic [2:0]  op_r;
  logic [31:0] tms_r, ts_r, load_r;
  logic [4:0]  mask_r;

  logic [31:0]              last_r, gap_r;
  logic                     first_r, idle_r;
  logic [pem_pkg::CNT_W-1:0] cnt_r [pem_pkg::NUM_CNT];
  logic [pem_pkg::PWR_W-1:0] power_r, peak_r;
  logic [pem_pkg::AVG_W-1:0] avg_r;
  logic [pem_pkg::EN_W-1:0]  en_r [pem_pkg::NUM_CNT];
  logic [pem_pkg::EN_W-1:0]  base_en_r;
  logic [31:0]              base_t_r;
  logic [pem_pkg::IDX_W-1:0] idx_r;

  logic        out_valid_r;
  logic [13:0] o_pwr_r, o_peak_r;
  logic [31:0] o_avg_r;
  logic [41:0] o_en_r [pem_pkg::NUM_CNT];
  logic        o_idle_r;

  logic [31:0]              d_ms, gap_new;
  logic                     tmo;
  logic [pem_pkg::EN_W-1:0]  cnt_x1000;
  logic [pem_pkg::EN_W-1:0]  en_diff;
  logic [pem_pkg::DVD_W-1:0] diff_x3600;
  logic                     out_free;

  pem_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .ppu     (ppu)
  );

  pem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign ppu_eff = (ppu == '0) ? pem_pkg::PPU_W'(1) : ppu;
  assign d_ms    = tms_r - last_r;
  assign tmo     = d_ms > pem_pkg::TIMEOUT_MS;
  assign gap_new = tmo ? 32'd0 :
                   ((power_r != '0) && (d_ms > gap_r)) ? d_ms : gap_r;
  assign cnt_x1000 = {cnt_r[idx_r], 10'd0} - {6'd0, cnt_r[idx_r], 4'd0}
                   - {7'd0, cnt_r[idx_r], 3'd0};
  assign en_diff    = en_r[4] - base_en_r;
  assign diff_x3600 = {en_diff, 12'd0} - {3'd0, en_diff, 9'd0} + {8'd0, en_diff, 4'd0};
  assign out_free   = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pem_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = pem_pkg::ST_EXEC;
      end
      pem_pkg::ST_EXEC: begin
        if (op_r == pem_pkg::OP_EVAL) begin
          state_nxt = (gap_new != '0) ? pem_pkg::ST_PWR_A_GO : pem_pkg::ST_EN_GO;
        end else begin
          state_nxt = pem_pkg::ST_DONE;
        end
      end
      pem_pkg::ST_PWR_A_GO:   state_nxt = pem_pkg::ST_PWR_A_WAIT;
      pem_pkg::ST_PWR_A_WAIT: if (div_done) state_nxt = pem_pkg::ST_PWR_B_GO;
      pem_pkg::ST_PWR_B_GO:   state_nxt = pem_pkg::ST_PWR_B_WAIT;
      pem_pkg::ST_PWR_B_WAIT: if (div_done) state_nxt = pem_pkg::ST_EN_GO;
      pem_pkg::ST_EN_GO:      state_nxt = pem_pkg::ST_EN_WAIT;
      pem_pkg::ST_EN_WAIT: begin
        if (div_done) begin
          state_nxt = (idx_r == pem_pkg::IDX_W'(pem_pkg::NUM_CNT - 1)) ?
                      pem_pkg::ST_AVG_GO : pem_pkg::ST_EN_GO;
        end
      end
      pem_pkg::ST_AVG_GO: begin
        if ((ts_r > base_t_r) && (en_r[4] >= base_en_r)) begin
          state_nxt = pem_pkg::ST_AVG_WAIT;
        end else begin
          state_nxt = pem_pkg::ST_DONE;
        end
      end
      pem_pkg::ST_AVG_WAIT:   if (div_done) state_nxt = pem_pkg::ST_DONE;
      pem_pkg::ST_DONE:       if (out_free) state_nxt = pem_pkg::ST_IDLE;
      default:                state_nxt = pem_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    in_ch.ready = 1'b0;
    case (state_r)
      pem_pkg::ST_IDLE: in_ch.ready = 1'b1;
      pem_pkg::ST_PWR_A_GO: begin
        div_start = 1'b1;
        div_dvd   = pem_pkg::POWER_NUM;
        div_dvs   = gap_r;
      end
      pem_pkg::ST_PWR_B_GO: begin
        div_start = 1'b1;
        div_dvd   = div_quo;
        div_dvs   = {16'd0, ppu_eff};
      end
      pem_pkg::ST_EN_GO: begin
        div_start = 1'b1;
        div_dvd   = {12'd0, cnt_x1000};
        div_dvs   = {16'd0, ppu_eff};
      end
      pem_pkg::ST_AVG_GO: begin
        div_start = (ts_r > base_t_r) && (en_r[4] >= base_en_r);
        div_dvd   = diff_x3600;
        div_dvs   = ts_r - base_t_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pem_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      gap_r       <= '0;
      first_r     <= 1'b1;
      idle_r      <= 1'b0;
      power_r     <= '0;
      peak_r      <= '0;
      avg_r       <= '0;
      base_en_r   <= '0;
      base_t_r    <= '0;
      idx_r       <= '0;
      for (int i = 0; i < pem_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= '0;
        en_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready && !((state_r == pem_pkg::ST_DONE) && out_free))
        out_valid_r <= 1'b0;
      case (state_r)
        pem_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            op_r   <= in_ch.opcode;
            tms_r  <= in_ch.time_ms;
            ts_r   <= in_ch.time_s;
            mask_r <= in_ch.counter_mask;
            load_r <= in_ch.load_value;
            idle_r <= 1'b0;
            idx_r  <= '0;
          end
        end
        pem_pkg::ST_EXEC: begin
          case (op_r)
            pem_pkg::OP_PULSE: begin
              if (first_r) first_r <= 1'b0;
              else         gap_r   <= tms_r - last_r;
              last_r <= tms_r;
              for (int i = 0; i < pem_pkg::NUM_CNT; i++) cnt_r[i] <= cnt_r[i] + 1'b1;
            end
            pem_pkg::OP_EVAL: begin
              gap_r <= gap_new;
              if (tmo) begin
                power_r <= '0;
                first_r <= 1'b1;
                idle_r  <= 1'b1;
              end
            end
            pem_pkg::OP_CNT_RESET: begin
              for (int i = 0; i < pem_pkg::NUM_CNT; i++)
                if (mask_r[i]) cnt_r[i] <= '0;
            end
            pem_pkg::OP_CNT_LOAD: begin
              for (int i = 0; i < pem_pkg::NUM_CNT; i++)
                if (mask_r[i]) cnt_r[i] <= load_r;
            end
            pem_pkg::OP_PEAK_RST: peak_r <= '0;
            pem_pkg::OP_AVG_RST: begin
              avg_r     <= '0;
              base_en_r <= en_r[4];
              base_t_r  <= ts_r;
            end
            default: ;
          endcase
        end
        pem_pkg::ST_PWR_B_WAIT: begin
          if (div_done) begin
            if (div_quo > {40'd0, pem_pkg::POWER_CLIP}) begin
              power_r <= pem_pkg::POWER_CLIP;
            end else begin
              power_r <= div_quo[pem_pkg::PWR_W-1:0];
              if (div_quo[pem_pkg::PWR_W-1:0] > peak_r)
                peak_r <= div_quo[pem_pkg::PWR_W-1:0];
            end
          end
        end
        pem_pkg::ST_EN_WAIT: begin
          if (div_done) begin
            en_r[idx_r] <= div_quo[pem_pkg::EN_W-1:0];
            idx_r       <= idx_r + 1'b1;
          end
        end
        pem_pkg::ST_AVG_GO: begin
          if ((ts_r > base_t_r) && (en_r[4] < base_en_r)) begin
            avg_r     <= '0;
            base_en_r <= en_r[4];
            base_t_r  <= ts_r;
          end
        end
        pem_pkg::ST_AVG_WAIT: begin
          if (div_done) begin
            avg_r <= (div_quo[pem_pkg::DVD_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                          : div_quo[31:0];
          end
        end
        pem_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_pwr_r     <= power_r;
            o_peak_r    <= peak_r;
            o_avg_r     <= avg_r;
            o_idle_r    <= idle_r;
            for (int i = 0; i < pem_pkg::NUM_CNT; i++) o_en_r[i] <= en_r[i];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_now    = o_pwr_r;
  assign out_ch.power_max    = o_peak_r;
  assign out_ch.power_avg    = o_avg_r;
  assign out_ch.energy_today = o_en_r[0];
  assign out_ch.energy_week  = o_en_r[1];
  assign out_ch.energy_month = o_en_r[2];
  assign out_ch.energy_year  = o_en_r[3];
  assign out_ch.energy_all   = o_en_r[4];
  assign out_ch.idle_timeout = o_idle_r;

endmodule
